// ===== rtl/kre_pkg.sv =====
// Shared types and constants for the Kalman RTT estimator.
// Used by kre_ctrl, kre_datapath and kalman_rtt_estimator; depends on nothing.
package kre_pkg;

   localparam int FIELD_W    = 32;  // width of the RTT fields on the stream ports
   localparam int REG_W      = 32;  // width of every configuration register
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_OUTPUT        = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_OUTPUT        = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SETUP,
      ST_DIV,
      ST_GAIN,
      ST_MUL,
      ST_UPDATE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_in;
      logic prep;
      logic setup;
      logic div_step;
      logic gain;
      logic mul_step;
      logic update;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic mul_last;
   } status_type;

   typedef struct packed {
      logic [REG_W-1:0] process_noise;
      logic [REG_W-1:0] measurement_noise;
      logic [REG_W-1:0] min_output;
      logic [REG_W-1:0] max_output;
   } cfg_type;

endpackage

// ===== rtl/kre_ctrl.sv =====
// Sequencer of the Kalman RTT estimator: steps one item through the datapath.
// Depends on kre_pkg for the state, command and status types.
module kre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  kre_pkg::status_type status,
   output kre_pkg::cmd_type    cmd
);

   kre_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kre_pkg::ST_IDLE:   if (req_tvalid) state_in = kre_pkg::ST_PREP;
         kre_pkg::ST_PREP:   state_in = kre_pkg::ST_SETUP;
         kre_pkg::ST_SETUP:  state_in = kre_pkg::ST_DIV;
         kre_pkg::ST_DIV:    if (status.div_last) state_in = kre_pkg::ST_GAIN;
         kre_pkg::ST_GAIN:   state_in = kre_pkg::ST_MUL;
         kre_pkg::ST_MUL:    if (status.mul_last) state_in = kre_pkg::ST_UPDATE;
         kre_pkg::ST_UPDATE: state_in = kre_pkg::ST_OUT;
         kre_pkg::ST_OUT:    if (slot_free) state_in = kre_pkg::ST_IDLE;
         default:            state_in = kre_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         kre_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         kre_pkg::ST_PREP:   cmd.prep     = 1'b1;
         kre_pkg::ST_SETUP:  cmd.setup    = 1'b1;
         kre_pkg::ST_DIV:    cmd.div_step = 1'b1;
         kre_pkg::ST_GAIN:   cmd.gain     = 1'b1;
         kre_pkg::ST_MUL:    cmd.mul_step = 1'b1;
         kre_pkg::ST_UPDATE: cmd.update   = 1'b1;
         kre_pkg::ST_OUT:    cmd.load_out = slot_free;
         default:            cmd          = '0;
      endcase
   end

   // Hold the result until taken; a new load may replace one taken this cycle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kre_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/kre_datapath.sv =====
// Datapath of the Kalman RTT estimator: filter state, restoring gain divider,
// shift-add multipliers, clamp and output register. Depends on kre_pkg.
module kre_datapath #(
   parameter int RTT_BITS  = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  kre_pkg::cmd_type                 cmd,
   output kre_pkg::status_type              status,
   input  kre_pkg::cfg_type                 cfg,
   input  logic [kre_pkg::FIELD_W-1:0]      meas_rtt,
   output logic [kre_pkg::FIELD_W-1:0]      out_rtt,
   output logic                             out_clamped
);

   localparam int S    = RTT_BITS + FRAC_BITS;
   localparam int WW   = ((S > kre_pkg::REG_W) ? S : kre_pkg::REG_W) + 1;
   localparam int PW   = S + FRAC_BITS + 1;
   localparam int CMPW = (RTT_BITS > kre_pkg::FIELD_W) ? RTT_BITS : kre_pkg::FIELD_W;
   localparam int CNTW = $clog2(FRAC_BITS + 1);
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [RTT_BITS-1:0]       meas_ff, meas_in;
   logic [S-1:0]              est_ff, est_in, cov_ff, cov_in;
   logic [S-1:0]              midp_ff, midp_in, diff_ff, diff_in;
   logic                      up_ff, up_in;
   logic [WW-1:0]             den_ff, den_in, rem_ff, rem_in;
   logic [FRAC_BITS:0]        quo_ff, quo_in, cg_ff, cg_in;
   logic [PW-1:0]             acc_e_ff, acc_e_in, acc_c_ff, acc_c_in;
   logic [CNTW-1:0]           cnt_ff, cnt_in;
   logic [kre_pkg::FIELD_W-1:0] out_rtt_ff, out_rtt_in;
   logic                      out_clamped_ff, out_clamped_in;

   logic [WW-1:0]             sum_p;
   logic [S-1:0]              midp_sat, meas_fx, step;
   logic [WW:0]               rem2;
   logic                      rem_ge, gain_one;
   logic [FRAC_BITS:0]        gain_fin;
   logic [CMPW-1:0]           e_ext, lo_ext, hi_ext, r_low;
   logic                      below, above;

   // Predicted covariance, saturated to the state width.
   assign sum_p    = WW'(cov_ff) + WW'(cfg.process_noise);
   assign midp_sat = (|sum_p[WW-1:S]) ? {S{1'b1}} : sum_p[S-1:0];
   assign meas_fx  = {meas_ff, {FRAC_BITS{1'b0}}};

   assign rem2     = {rem_ff, 1'b0};
   assign rem_ge   = rem2 >= {1'b0, den_ff};
   // Zero measurement noise makes the gain exactly one.
   assign gain_one = cfg.measurement_noise == '0;
   assign gain_fin = gain_one ? ONE : quo_ff;
   assign step     = acc_e_ff[S+FRAC_BITS-1:FRAC_BITS];

   // Clamp: low bound first, high bound second.
   assign e_ext  = CMPW'(est_ff[S-1:FRAC_BITS]);
   assign lo_ext = CMPW'(cfg.min_output);
   assign hi_ext = CMPW'(cfg.max_output);
   assign below  = e_ext < lo_ext;
   assign r_low  = below ? lo_ext : e_ext;
   assign above  = r_low > hi_ext;

   always_comb begin
      meas_in        = meas_ff;
      est_in         = est_ff;
      cov_in         = cov_ff;
      midp_in        = midp_ff;
      diff_in        = diff_ff;
      up_in          = up_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cg_in          = cg_ff;
      acc_e_in       = acc_e_ff;
      acc_c_in       = acc_c_ff;
      cnt_in         = cnt_ff;
      out_rtt_in     = out_rtt_ff;
      out_clamped_in = out_clamped_ff;
      if (cmd.load_in) begin
         meas_in = RTT_BITS'(meas_rtt);
      end
      if (cmd.prep) begin
         midp_in = midp_sat;
         up_in   = meas_fx >= est_ff;
         diff_in = (meas_fx >= est_ff) ? (meas_fx - est_ff) : (est_ff - meas_fx);
      end
      if (cmd.setup) begin
         den_in = WW'(midp_ff) + WW'(cfg.measurement_noise);
         rem_in = WW'(midp_ff);
         quo_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = rem_ge ? WW'(rem2 - {1'b0, den_ff}) : rem2[WW-1:0];
         quo_in = {quo_ff[FRAC_BITS-1:0], rem_ge};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.gain) begin
         quo_in   = gain_fin;
         cg_in    = ONE - gain_fin;
         acc_e_in = '0;
         acc_c_in = '0;
         cnt_in   = '0;
      end
      // MSB-first shift-add: gain times difference and (1 - gain) times covariance.
      if (cmd.mul_step) begin
         acc_e_in = {acc_e_ff[PW-2:0], 1'b0} + (quo_ff[FRAC_BITS] ? PW'(diff_ff) : '0);
         acc_c_in = {acc_c_ff[PW-2:0], 1'b0} + (cg_ff[FRAC_BITS] ? PW'(midp_ff) : '0);
         quo_in   = {quo_ff[FRAC_BITS-1:0], 1'b0};
         cg_in    = {cg_ff[FRAC_BITS-1:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
      end
      if (cmd.update) begin
         est_in = up_ff ? (est_ff + step) : (est_ff - step);
         cov_in = acc_c_ff[S+FRAC_BITS-1:FRAC_BITS];
      end
      if (cmd.load_out) begin
         out_rtt_in     = above ? hi_ext[kre_pkg::FIELD_W-1:0] : r_low[kre_pkg::FIELD_W-1:0];
         out_clamped_in = below || above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= '0;
         cov_ff <= '0;
      end else begin
         est_ff <= est_in;
         cov_ff <= cov_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff        <= meas_in;
      midp_ff        <= midp_in;
      diff_ff        <= diff_in;
      up_ff          <= up_in;
      den_ff         <= den_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      cg_ff          <= cg_in;
      acc_e_ff       <= acc_e_in;
      acc_c_ff       <= acc_c_in;
      cnt_ff         <= cnt_in;
      out_rtt_ff     <= out_rtt_in;
      out_clamped_ff <= out_clamped_in;
   end

   assign status.div_last = cnt_ff == CNTW'(FRAC_BITS - 1);
   assign status.mul_last = cnt_ff == CNTW'(FRAC_BITS);
   assign out_rtt         = out_rtt_ff;
   assign out_clamped     = out_clamped_ff;

endmodule

// ===== rtl/kalman_rtt_estimator.sv =====
// Top level of the Kalman RTT estimator: configuration registers, sequencer
// and datapath. Depends on kre_pkg, kre_ctrl and kre_datapath.
//
// Usage:
//   req_* carries one measured RTT sample per item; rsp_* returns one item per
//   sample: the filtered estimate clamped to [min_output, max_output] in
//   rsp_tdata and a clamp flag in rsp_tuser. csr_* writes the four registers
//   (process noise, measurement noise, min and max output); write them only
//   while no item is in flight.
//   Each item walks through the datapath one step per cycle, stalling only
//   in the output stage until the output register frees: a restoring
//   divider produces one gain bit per cycle, then two shift-add multipliers
//   consume one gain bit per cycle. req_tready is high only while no sample
//   is being worked on. The finished item sits in an output register, so the
//   next sample is accepted while it waits; if the receiver still stalls when
//   the next item is done, that item waits in the sequencer until the output
//   register frees.
//   Reset clears estimate and covariance and loads the register defaults.
module kalman_rtt_estimator #(
   parameter int RTT_BITS  = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [kre_pkg::FIELD_W-1:0]        req_tdata,  // [31:0] measured_rtt
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [kre_pkg::FIELD_W-1:0]        rsp_tdata,  // [31:0] predicted_rtt
   output logic                               rsp_tuser,  // [0] was_clamped
   input  logic                               csr_we,
   input  logic [kre_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [kre_pkg::REG_W-1:0]          csr_wdata
);

   kre_pkg::cfg_type    cfg_ff, cfg_in;
   kre_pkg::cmd_type    cmd;
   kre_pkg::status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            kre_pkg::REG_PROCESS_NOISE:     cfg_in.process_noise     = csr_wdata;
            kre_pkg::REG_MEASUREMENT_NOISE: cfg_in.measurement_noise = csr_wdata;
            kre_pkg::REG_MIN_OUTPUT:        cfg_in.min_output        = csr_wdata;
            kre_pkg::REG_MAX_OUTPUT:        cfg_in.max_output        = csr_wdata;
            default:                        cfg_in                   = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.process_noise     <= kre_pkg::REG_W'(65536);
         cfg_ff.measurement_noise <= kre_pkg::REG_W'(65536);
         cfg_ff.min_output        <= '0;
         cfg_ff.max_output        <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kre_datapath #(
      .RTT_BITS  (RTT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .cfg         (cfg_ff),
      .meas_rtt    (req_tdata),
      .out_rtt     (rsp_tdata),
      .out_clamped (rsp_tuser)
   );

   // An accepted sample starts its work in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (cmd.prep && !req_tready))
      else $error("accepted sample did not start");

   // Never overwrite a result the receiver has not taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten");

   // The estimate is written back exactly once, right before the output stage.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (!cmd.update && !req_tready))
      else $error("update not followed by output stage");

endmodule
